@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the fused multiply-add block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same-cycle implication)");
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next-cycle implication)");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/fpfma_pkg.sv @@
// Shared types, constants and normalize helpers for the fused multiply-add.
// No dependencies; every RTL module imports this package.
`default_nettype none

package fpfma_pkg;

  // Number of register stages from input beat to output register.
  localparam int NSTG = 11;

  typedef logic signed [15:0] exp_t;
  typedef logic [52:0]        man_t;

  // Exponent constants for both formats.
  localparam exp_t BMB64    = 16'sd1075;  // bias plus fraction bits
  localparam exp_t BMB32    = 16'sd150;
  localparam exp_t PSH_HI   = 16'sd20;
  localparam exp_t PSH_LO   = 16'sd21;
  localparam exp_t ZSH      = 16'sd73;
  localparam exp_t EOFF     = 16'sd127;
  localparam exp_t EMIN64   = -16'sd1022;
  localparam exp_t EMIN32   = -16'sd126;
  localparam exp_t BIAS64   = 16'sd1023;
  localparam exp_t BIAS32   = 16'sd127;
  localparam exp_t EMAXF64  = 16'sd2047;
  localparam exp_t EMAXF32  = 16'sd255;
  localparam exp_t DROP64   = 16'sd11;
  localparam exp_t DROP32   = 16'sd40;
  localparam exp_t DROP_MAX = 16'sd64;
  localparam exp_t DSAT     = 16'sd255;

  // Bit patterns for both formats.
  localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] INF32  = 64'h0000_0000_7F80_0000;
  localparam logic [63:0] QNAN64 = 64'h0008_0000_0000_0000;
  localparam logic [63:0] QNAN32 = 64'h0000_0000_0040_0000;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN32 = 64'h0000_0000_8000_0000;

  // Per-item information that bypasses the datapath.
  typedef struct packed {
    logic        dp;
    logic        last;
    logic        spec;
    logic [63:0] val;
  } side_t;

  // Unpacked operands with normalized significands.
  typedef struct packed {
    logic dp;
    logic sp;
    logic sz;
    logic zz;
    man_t mx;
    man_t my;
    man_t mz;
    exp_t ex;
    exp_t ey;
    exp_t ez;
  } unp_t;

  // Exact product plus addend.
  typedef struct packed {
    logic         dp;
    logic         sp;
    logic         sz;
    logic         zz;
    logic [105:0] p;
    exp_t         ep;
    man_t         mz;
    exp_t         ez;
  } mul_t;

  // Raw sum or difference of the aligned operands.
  typedef struct packed {
    logic         dp;
    logic         sub;
    logic         sb;
    logic         ss;
    exp_t         eb;
    logic [128:0] r;
  } add_t;

  typedef struct packed {
    logic [5:0]  cnt;
    logic [63:0] val;
  } norm64_t;

  typedef struct packed {
    logic [6:0]   cnt;
    logic [127:0] val;
  } norm128_t;

  // Left-normalize a 64-bit word in six halving steps.
  function automatic norm64_t norm64(input logic [63:0] a);
    norm64_t r;
    r.val = a;
    r.cnt = '0;
    if (r.val[63:32] == '0) begin
      r.val = {r.val[31:0], 32'b0};
      r.cnt[5] = 1'b1;
    end
    if (r.val[63:48] == '0) begin
      r.val = {r.val[47:0], 16'b0};
      r.cnt[4] = 1'b1;
    end
    if (r.val[63:56] == '0) begin
      r.val = {r.val[55:0], 8'b0};
      r.cnt[3] = 1'b1;
    end
    if (r.val[63:60] == '0) begin
      r.val = {r.val[59:0], 4'b0};
      r.cnt[2] = 1'b1;
    end
    if (r.val[63:62] == '0) begin
      r.val = {r.val[61:0], 2'b0};
      r.cnt[1] = 1'b1;
    end
    if (r.val[63] == 1'b0) begin
      r.val = {r.val[62:0], 1'b0};
      r.cnt[0] = 1'b1;
    end
    return r;
  endfunction

  // Left-normalize a 128-bit word in seven halving steps.
  function automatic norm128_t norm128(input logic [127:0] a);
    norm128_t r;
    r.val = a;
    r.cnt = '0;
    if (r.val[127:64] == '0) begin
      r.val = {r.val[63:0], 64'b0};
      r.cnt[6] = 1'b1;
    end
    if (r.val[127:96] == '0) begin
      r.val = {r.val[95:0], 32'b0};
      r.cnt[5] = 1'b1;
    end
    if (r.val[127:112] == '0) begin
      r.val = {r.val[111:0], 16'b0};
      r.cnt[4] = 1'b1;
    end
    if (r.val[127:120] == '0) begin
      r.val = {r.val[119:0], 8'b0};
      r.cnt[3] = 1'b1;
    end
    if (r.val[127:124] == '0) begin
      r.val = {r.val[123:0], 4'b0};
      r.cnt[2] = 1'b1;
    end
    if (r.val[127:126] == '0) begin
      r.val = {r.val[125:0], 2'b0};
      r.cnt[1] = 1'b1;
    end
    if (r.val[127] == 1'b0) begin
      r.val = {r.val[126:0], 1'b0};
      r.cnt[0] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/fp_fused_multiply_add.sv @@
// Top level of the IEEE 754 fused multiply-add pipeline.
// Depends on fpfma_pkg, fpfma_unpack, fpfma_mul, fpfma_align, fpfma_round
// and assert_macros.svh.
//
// Usage:
//   Configuration: a beat on cfg_valid/cfg_ready writes double_precision
//   (1 = binary64, 0 = binary32). cfg_ready is always high. Write it only
//   while the pipeline is empty.
//   Input: one beat per element on in_valid/in_ready carries operand_x,
//   operand_y, addend_z and last_in. Output: one beat per element on
//   out_valid/out_ready carries fma_result (x*y+z, rounded once to nearest
//   even) and last_out, in input order.
//   out_valid rises when the element reaches the last register stage; one
//   element can be taken every cycle while out_ready stays high. The eleven
//   register stages are: unpack, two multiplier stages, three align/add
//   stages, five normalize/round stages.
//   Reset clears all stage valid bits and selects binary32.
//   When the receiver holds out_ready low, each stage holds its item only
//   while the stage after it is also full, so bubbles close up and the
//   block keeps taking input until all eleven stages are occupied.
`default_nettype none
`include "assert_macros.svh"

module fp_fused_multiply_add
  import fpfma_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        double_precision,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] operand_x,
  input  wire logic [63:0] operand_y,
  input  wire logic [63:0] addend_z,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      fma_result,
  output logic             last_out
);

  logic            dp_mode;
  logic [NSTG:1]   v;
  logic [NSTG:1]   en;
  unp_t            u;
  side_t           side1;
  side_t           side_q [2:NSTG];
  mul_t            mres;
  add_t            ares;
  logic [63:0]     nr_res;

  // Format register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_mode <= 1'b0;
    end else if (cfg_valid) begin
      dp_mode <= double_precision;
    end
  end

  // Stage enables: a stage loads when it is empty or its item moves on.
  always_comb begin
    en[NSTG] = !v[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k + 1];
    end
  end

  assign in_ready = en[1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k - 1];
        end
      end
    end
  end

  // Bypass data: mode, last mark and any special-case result.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_q[2] <= side1;
    end
    for (int k = 3; k <= NSTG; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k - 1];
      end
    end
  end

  fpfma_unpack u_unpack (
    .clk  (clk),
    .en   (en[1]),
    .dp   (dp_mode),
    .x    (operand_x),
    .y    (operand_y),
    .z    (addend_z),
    .last (last_in),
    .u    (u),
    .s    (side1)
  );

  fpfma_mul u_mul (
    .clk (clk),
    .en  (en[3:2]),
    .u   (u),
    .m   (mres)
  );

  fpfma_align u_align (
    .clk (clk),
    .en  (en[6:4]),
    .m   (mres),
    .a   (ares)
  );

  fpfma_round u_round (
    .clk (clk),
    .en  (en[11:7]),
    .a   (ares),
    .res (nr_res)
  );

  // Output beat.
  assign out_valid  = v[NSTG];
  assign fma_result = side_q[NSTG].spec ? side_q[NSTG].val : nr_res;
  assign last_out   = side_q[NSTG].last;

  // Checks.
  `ASSERT_IMPLY(a_sp_upper_zero, clk, rst, out_valid && !side_q[NSTG].dp, fma_result[63:32] == 32'h0)
  `ASSERT_IMPLY(a_stall_only_full, clk, rst, !in_ready, v[NSTG] && !out_ready)
  `ASSERT_NEXT(a_beat_enters, clk, rst, in_valid && in_ready, v[1])

endmodule

`default_nettype wire

@@ sv/fpfma_unpack.sv @@
// Stage 1 of the fused multiply-add: unpack, classify, special results.
// Depends on fpfma_pkg.
`default_nettype none

module fpfma_unpack
  import fpfma_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        dp,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  input  wire logic [63:0] z,
  input  wire logic        last,
  output unp_t             u,
  output side_t            s
);

  typedef struct packed {
    logic sign;
    logic nan;
    logic inf;
    logic zero;
    man_t m;
    exp_t e;
  } op_t;

  // Split one operand and normalize its significand to bit 52.
  function automatic op_t classify(input logic [63:0] b, input logic mode);
    logic [10:0] exf;
    logic [10:0] exf1;
    logic [51:0] frac;
    logic [10:0] emaxv;
    man_t        m;
    exp_t        eraw;
    norm64_t     nm;
    op_t         o;
    exf   = mode ? b[62:52] : {3'b0, b[30:23]};
    frac  = mode ? b[51:0] : {29'b0, b[22:0]};
    emaxv = mode ? 11'h7FF : 11'h0FF;
    o.sign = mode ? b[63] : b[31];
    o.nan  = (exf == emaxv) && (frac != '0);
    o.inf  = (exf == emaxv) && (frac == '0);
    o.zero = (exf == '0) && (frac == '0);
    m = mode ? {exf != '0, frac} : {29'b0, exf != '0, b[22:0]};
    exf1 = (exf == '0) ? 11'd1 : exf;
    eraw = exp_t'({5'b0, exf1}) - (mode ? BMB64 : BMB32);
    nm   = norm64({m, 11'b0});
    o.m  = nm.val[63:11];
    o.e  = eraw - exp_t'({10'b0, nm.cnt});
    return o;
  endfunction

  op_t         ox, oy, oz;
  logic [63:0] xm, ym, zm;
  logic [63:0] quiet, signb, infb, defnan;
  logic        sp;
  logic        spec;
  logic [63:0] val;

  // Classification and the results that bypass the arithmetic.
  always_comb begin
    xm = dp ? x : {32'b0, x[31:0]};
    ym = dp ? y : {32'b0, y[31:0]};
    zm = dp ? z : {32'b0, z[31:0]};
    ox = classify(xm, dp);
    oy = classify(ym, dp);
    oz = classify(zm, dp);
    quiet  = dp ? QNAN64 : QNAN32;
    signb  = dp ? SIGN64 : SIGN32;
    infb   = dp ? INF64 : INF32;
    defnan = signb | infb | quiet;
    sp     = ox.sign ^ oy.sign;
    spec   = 1'b1;
    val    = '0;
    if (ox.nan) begin
      val = xm | quiet;
    end else if (oy.nan) begin
      val = ym | quiet;
    end else if (oz.nan) begin
      val = zm | quiet;
    end else if (ox.inf || oy.inf) begin
      if (ox.zero || oy.zero || (oz.inf && (oz.sign != sp))) begin
        val = defnan;
      end else begin
        val = (sp ? signb : '0) | infb;
      end
    end else if (oz.inf) begin
      val = zm;
    end else if (ox.zero || oy.zero) begin
      if (oz.zero) begin
        val = (sp && oz.sign) ? signb : '0;
      end else begin
        val = zm;
      end
    end else begin
      spec = 1'b0;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (en) begin
      u.dp <= dp;
      u.sp <= sp;
      u.sz <= oz.sign;
      u.zz <= oz.zero;
      u.mx <= ox.m;
      u.my <= oy.m;
      u.mz <= oz.m;
      u.ex <= ox.e;
      u.ey <= oy.e;
      u.ez <= oz.e;
      s.dp   <= dp;
      s.last <= last;
      s.spec <= spec;
      s.val  <= val;
    end
  end

endmodule

`default_nettype wire

@@ sv/fpfma_mul.sv @@
// Stages 2 and 3: 53x53 significand product from four partial products.
// Depends on fpfma_pkg.
`default_nettype none

module fpfma_mul
  import fpfma_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [1:0] en,
  input  unp_t            u,
  output mul_t            m
);

  logic [53:0] pll;
  logic [52:0] plh, phl;
  logic [51:0] phh;
  unp_t        u2;

  // Stage 2: four partial products, each at most 27 by 27 bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pll <= u.mx[26:0] * u.my[26:0];
      plh <= u.mx[26:0] * u.my[52:27];
      phl <= u.mx[52:27] * u.my[26:0];
      phh <= u.mx[52:27] * u.my[52:27];
      u2  <= u;
    end
  end

  // Stage 3: sum the partial products and the product exponent.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m.dp <= u2.dp;
      m.sp <= u2.sp;
      m.sz <= u2.sz;
      m.zz <= u2.zz;
      m.p  <= 106'(pll) + (106'(plh) << 27) + (106'(phl) << 27) + (106'(phh) << 54);
      m.ep <= u2.ex + u2.ey;
      m.mz <= u2.mz;
      m.ez <= u2.ez;
    end
  end

endmodule

`default_nettype wire

@@ sv/fpfma_align.sv @@
// Stages 4 to 6: place product and addend, align the smaller, add or subtract.
// Depends on fpfma_pkg.
`default_nettype none

module fpfma_align
  import fpfma_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [2:0] en,
  input  mul_t            m,
  output add_t            a
);

  typedef struct packed {
    logic         dp;
    logic         sub;
    logic         sb;
    logic         ss;
    exp_t         eb;
    logic [127:0] opa;
    logic [127:0] opb;
    logic [7:0]   d;
  } al_t;

  al_t          c4, s4, c5, s5;
  logic [127:0] p128, z128;
  exp_t         epn, es, dd, dmag;
  logic [127:0] opb_sh;

  // Stage 4: both operands with the leading one at bit 125, then order them.
  always_comb begin
    p128 = m.p[105] ? {2'b0, m.p, 20'b0} : {2'b0, m.p[104:0], 21'b0};
    epn  = m.ep - (m.p[105] ? PSH_HI : PSH_LO);
    z128 = {2'b0, m.mz, 73'b0};
    es   = m.ez - ZSH;
    dd   = epn - es;
    c4.dp = m.dp;
    if (m.zz) begin
      c4.opa = p128;
      c4.eb  = epn;
      c4.sb  = m.sp;
      c4.opb = '0;
      c4.ss  = m.sp;
      dmag   = '0;
    end else if (!dd[15]) begin
      c4.opa = p128;
      c4.eb  = epn;
      c4.sb  = m.sp;
      c4.opb = z128;
      c4.ss  = m.sz;
      dmag   = dd;
    end else begin
      c4.opa = z128;
      c4.eb  = es;
      c4.sb  = m.sz;
      c4.opb = p128;
      c4.ss  = m.sp;
      dmag   = -dd;
    end
    c4.d   = (dmag > DSAT) ? 8'hFF : dmag[7:0];
    c4.sub = c4.sb ^ c4.ss;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4 <= c4;
    end
  end

  // Stage 5: shift the smaller operand right, folding lost bits into bit 0.
  always_comb begin
    if (s4.d[7]) begin
      opb_sh = {127'b0, |s4.opb};
    end else begin
      opb_sh = (s4.opb >> s4.d[6:0])
             | {127'b0, |(s4.opb & ~({128{1'b1}} << s4.d[6:0]))};
    end
    c5     = s4;
    c5.opb = opb_sh;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s5 <= c5;
    end
  end

  // Stage 6: magnitude add or subtract with the borrow kept in bit 128.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      a.dp  <= s5.dp;
      a.sub <= s5.sub;
      a.sb  <= s5.sb;
      a.ss  <= s5.ss;
      a.eb  <= s5.eb;
      a.r   <= s5.sub ? ({1'b0, s5.opa} - {1'b0, s5.opb})
                      : ({1'b0, s5.opa} + {1'b0, s5.opb});
    end
  end

endmodule

`default_nettype wire

@@ sv/fpfma_round.sv @@
// Stages 7 to 11: sign fix, normalize, round to nearest even and pack.
// Depends on fpfma_pkg.
`default_nettype none

module fpfma_round
  import fpfma_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [4:0]  en,
  input  add_t             a,
  output logic [63:0]      res
);

  typedef struct packed {
    logic         dp;
    logic         zres;
    logic         sr;
    exp_t         eb;
    logic [127:0] r;
  } s7_t;

  typedef struct packed {
    logic        dp;
    logic        zres;
    logic        sr;
    exp_t        e;
    logic [63:0] sig;
  } s8_t;

  typedef struct packed {
    logic        dp;
    logic        zres;
    logic        sr;
    logic        tiny;
    logic        ovf;
    logic        zq;
    logic [6:0]  drop;
    logic [10:0] fe;
    logic [63:0] sig;
  } s9_t;

  typedef struct packed {
    logic        dp;
    logic        zres;
    logic        sr;
    logic        tiny;
    logic        ovf;
    logic [10:0] fe;
    logic [53:0] q;
    logic        rup;
  } s10_t;

  s7_t      c7, s7;
  s8_t      c8, s8;
  s9_t      c9, s9;
  s10_t     c10, s10;
  logic     neg;
  norm128_t nr;
  exp_t     emin, bias, emaxf, base, dfull, few;
  logic [63:0] mask, rem, half, q64;
  logic [53:0] qr;
  logic [63:0] fld;
  logic        bigovf;
  logic [63:0] res_next;

  // Stage 7: a negative difference flips sign; an exact cancel gives +0.
  always_comb begin
    neg     = a.sub && a.r[128];
    c7.dp   = a.dp;
    c7.zres = a.sub && (a.r == '0);
    c7.sr   = neg ? a.ss : a.sb;
    c7.eb   = a.eb;
    c7.r    = neg ? (~a.r[127:0] + 128'd1) : a.r[127:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7 <= c7;
    end
  end

  // Stage 8: leading one to bit 127, fold the low half into a sticky bit.
  always_comb begin
    nr      = norm128(s7.r);
    c8.dp   = s7.dp;
    c8.zres = s7.zres;
    c8.sr   = s7.sr;
    c8.e    = s7.eb - exp_t'({9'b0, nr.cnt}) + EOFF;
    c8.sig  = nr.val[127:64] | {63'b0, |nr.val[63:0]};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s8 <= c8;
    end
  end

  // Stage 9: rounding position, tiny and overflow detection.
  always_comb begin
    emin  = s8.dp ? EMIN64 : EMIN32;
    bias  = s8.dp ? BIAS64 : BIAS32;
    emaxf = s8.dp ? EMAXF64 : EMAXF32;
    base  = s8.dp ? DROP64 : DROP32;
    dfull = base + (emin - s8.e);
    few   = s8.e + bias - 16'sd1;
    c9.dp   = s8.dp;
    c9.zres = s8.zres;
    c9.sr   = s8.sr;
    c9.tiny = s8.e < emin;
    c9.zq   = c9.tiny && (dfull > DROP_MAX);
    c9.drop = c9.tiny ? dfull[6:0] : base[6:0];
    c9.ovf  = !c9.tiny && ((s8.e + bias) >= emaxf);
    c9.fe   = few[10:0];
    c9.sig  = s8.sig;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s9 <= c9;
    end
  end

  // Stage 10: truncated significand and the round-up decision.
  always_comb begin
    q64  = s9.sig >> s9.drop;
    mask = ~({64{1'b1}} << s9.drop);
    rem  = s9.sig & mask;
    half = 64'd1 << (s9.drop - 7'd1);
    c10.dp   = s9.dp;
    c10.zres = s9.zres;
    c10.sr   = s9.sr;
    c10.tiny = s9.tiny;
    c10.ovf  = s9.ovf;
    c10.fe   = s9.fe;
    c10.q    = s9.zq ? '0 : q64[53:0];
    c10.rup  = !s9.zq && ((rem > half) || ((rem == half) && q64[0]));
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s10 <= c10;
    end
  end

  // Stage 11: increment, attach the exponent and catch a carry to infinity.
  always_comb begin
    qr = s10.q + 54'(s10.rup);
    if (s10.dp) begin
      fld    = s10.tiny ? 64'(qr) : ({1'b0, s10.fe, 52'b0} + 64'(qr));
      bigovf = s10.ovf || (fld[63:52] >= 12'h7FF);
    end else begin
      fld    = s10.tiny ? 64'(qr) : ({33'b0, s10.fe[7:0], 23'b0} + 64'(qr));
      bigovf = s10.ovf || (fld[63:23] >= 41'd255);
    end
    if (s10.zres) begin
      res_next = '0;
    end else if (s10.dp) begin
      res_next = {s10.sr, bigovf ? INF64[62:0] : fld[62:0]};
    end else begin
      res_next = {32'b0, s10.sr, bigovf ? INF32[30:0] : fld[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the fp_fused_multiply_add block (binary32 and binary64).
// Depends on fpfma_pkg and the block's RTL.
// Operands are random or directed; each result is checked against a bit-exact FMA predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpfma_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Bit-exact fused multiply-add predictor and the queue of expected results.
  class fma_scoreboard;
    bit          dp_mode;
    logic [63:0] pending_res[$];
    bit          pending_last[$];
    int          errors;
    int          checked;

    static function int lead_zeros(logic [127:0] w);
      int n;
      n = 0;
      for (int k = 127; k >= 0; k--) begin
        if (w[k]) break;
        n++;
      end
      return n;
    endfunction

    // Shift right; any bit shifted out is folded into bit 0.
    static function logic [127:0] shr_sticky(logic [127:0] w, int n);
      logic [127:0] mask;
      if (n <= 0) return w;
      if (n >= 128) return {127'b0, |w};
      mask = (128'b1 << n) - 1;
      return (w >> n) | {127'b0, |(w & mask)};
    endfunction

    static function logic [63:0] fused_round(logic [63:0] xb, logic [63:0] yb,
                                             logic [63:0] zb, int mb, int eb);
      logic [63:0]  signbit, mask, fmask, emaxf, infb, quiet, fld, sig, q, rem, half;
      logic [63:0]  ops[3];
      logic [63:0]  man[3];
      logic [127:0] prod, zw, big, sml, acc;
      int           ex[3];
      bit           sg[3], isnan[3], isinf[3], iszero[3];
      int           bias, emin, sp, ep, es, ebig, er, sr, sbig, ssml, d, sh, ee, drop;
      signbit = 64'd1 << (eb + mb);
      mask    = (signbit << 1) - 1;
      fmask   = (64'd1 << mb) - 1;
      emaxf   = (64'd1 << eb) - 1;
      infb    = emaxf << mb;
      quiet   = 64'd1 << (mb - 1);
      bias    = (1 << (eb - 1)) - 1;
      emin    = 1 - bias;
      ops[0] = xb & mask;
      ops[1] = yb & mask;
      ops[2] = zb & mask;
      for (int k = 0; k < 3; k++) begin
        logic [63:0] f, ef;
        f  = ops[k] & fmask;
        ef = (ops[k] >> mb) & emaxf;
        sg[k]     = (ops[k] & signbit) != 0;
        isnan[k]  = (ef == emaxf) && (f != 0);
        isinf[k]  = (ef == emaxf) && (f == 0);
        iszero[k] = (ops[k] & ~signbit) == 0;
        if (ef == 0) begin
          man[k] = f;
          ex[k]  = 1 - bias - mb;
        end else begin
          man[k] = f | (64'd1 << mb);
          ex[k]  = int'(ef) - bias - mb;
        end
      end
      // NaN operands propagate, quieted, in operand order.
      for (int k = 0; k < 3; k++)
        if (isnan[k]) return ops[k] | quiet;
      sp = sg[0] ^ sg[1];
      if (isinf[0] || isinf[1]) begin
        if (iszero[0] || iszero[1]) return signbit | infb | quiet;
        if (isinf[2] && sg[2] != sp) return signbit | infb | quiet;
        return (sp ? signbit : 64'd0) | infb;
      end
      if (isinf[2]) return ops[2];
      if (iszero[0] || iszero[1]) begin
        if (iszero[2]) return (sp && sg[2]) ? signbit : 64'd0;
        return ops[2];
      end
      // Exact product with its top bit at bit 125.
      prod = {64'b0, man[0]} * {64'b0, man[1]};
      ep   = ex[0] + ex[1];
      sh   = lead_zeros(prod) - 2;
      prod = prod << sh;
      ep   = ep - sh;
      acc  = prod;
      er   = ep;
      sr   = sp;
      if (!iszero[2]) begin
        zw = {64'b0, man[2]};
        sh = lead_zeros(zw) - 2;
        zw = zw << sh;
        es = ex[2] - sh;
        if (ep >= es) begin
          big = prod; ebig = ep; sbig = sp; sml = zw; ssml = sg[2]; d = ep - es;
        end else begin
          big = zw; ebig = es; sbig = sg[2]; sml = prod; ssml = sp; d = es - ep;
        end
        sml = shr_sticky(sml, d);
        er  = ebig;
        if (sbig == ssml) begin
          acc = big + sml;
          sr  = sbig;
        end else if (big == sml) begin
          return 64'd0;
        end else if (big > sml) begin
          acc = big - sml;
          sr  = sbig;
        end else begin
          acc = sml - big;
          sr  = ssml;
        end
      end
      // Normalize to bit 127 and fold the low half into a sticky bit.
      sh  = lead_zeros(acc);
      acc = acc << sh;
      er  = er - sh;
      ee  = er + 127;
      sig = acc[127:64] | {63'b0, acc[63:0] != 0};
      drop = 63 - mb;
      if (ee < emin) drop = (emin - ee > 64) ? 65 : drop + (emin - ee);
      if (ee >= emin && ee + bias >= int'(emaxf)) return (sr ? signbit : 64'd0) | infb;
      if (drop > 64) begin
        q = 0;
      end else begin
        if (drop == 64) begin
          q   = 0;
          rem = sig;
        end else begin
          q   = sig >> drop;
          rem = sig & ((64'd1 << drop) - 1);
        end
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
      end
      if (ee >= emin) begin
        fld = (64'(ee + bias - 1) << mb) + q;
        if ((fld >> mb) >= emaxf) return (sr ? signbit : 64'd0) | infb;
      end else begin
        fld = q;
      end
      return (sr ? signbit : 64'd0) | fld;
    endfunction

    function void note_input(logic [63:0] x, logic [63:0] y, logic [63:0] z, bit last);
      logic [63:0] r;
      if (dp_mode) begin
        r = fused_round(x, y, z, 52, 11);
      end else begin
        r = fused_round({32'b0, x[31:0]}, {32'b0, y[31:0]}, {32'b0, z[31:0]}, 23, 8);
        r = {32'b0, r[31:0]};
      end
      pending_res.push_back(r);
      pending_last.push_back(last);
    endfunction

    function void check_result(logic [63:0] res, logic last);
      logic [63:0] er;
      bit          el;
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected: fma_result=%h", res);
        errors++;
        return;
      end
      er = pending_res.pop_front();
      el = pending_last.pop_front();
      checked++;
      if (res !== er) begin
        $error("fma_result mismatch: expected %h, actual %h", er, res);
        errors++;
      end
      if (last !== el) begin
        $error("last_out mismatch: expected %0b, actual %0b", el, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_valid, cfg_ready, double_precision;
  logic        in_valid, in_ready, last_in;
  logic [63:0] operand_x, operand_y, addend_z;
  logic        out_valid, out_ready, last_out;
  logic [63:0] fma_result;

  fma_scoreboard fma_sb;
  int  snd_idle_pct, rcv_idle_pct;
  int  stall_left;
  int  cycles;
  int  accepted;

  fp_fused_multiply_add i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .double_precision(double_precision),
    .in_valid(in_valid), .in_ready(in_ready),
    .operand_x(operand_x), .operand_y(operand_y), .addend_z(addend_z), .last_in(last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .fma_result(fma_result), .last_out(last_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off while stall_left counts down.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) fma_sb.check_result(fma_result, last_out);
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", fma_sb.pending_res.size());
      $display("fp_fused_multiply_add test failed");
      $finish;
    end
  end

  // Offer one input beat and hold it until accepted; each cycle may idle first.
  task automatic send_item(logic [63:0] x, logic [63:0] y, logic [63:0] z, bit last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operand_x <= x;
    operand_y <= y;
    addend_z  <= z;
    last_in   <= last;
    do @(posedge clk); while (!in_ready);
    fma_sb.note_input(x, y, z, last);
    accepted++;
  endtask

  // Stop sending and wait until the pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    while (fma_sb.pending_res.size() != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
  endtask

  task automatic write_precision(bit v);
    drain();
    cfg_valid        <= 1'b1;
    double_precision <= v;
    do @(posedge clk); while (!cfg_ready);
    fma_sb.dp_mode = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] special_operand(bit dp);
    logic [63:0] s64[8] = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                            64'h7FF0_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h1,
                            64'h3FF0_0000_0000_0000, 64'h0010_0000_0000_0000};
    logic [31:0] s32[8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'h7F80_0001,
                            32'h7F7F_FFFF, 32'h1, 32'h3F80_0000, 32'h0080_0000};
    int k;
    bit s;
    k = $urandom_range(7);
    s = $urandom_range(1);
    if (dp) return s64[k] ^ {s, 63'b0};
    return {$urandom, s32[k] ^ {s, 31'b0}};
  endfunction

  // Random operand: raw bits, specials, values near one, subnormals, extreme exponents.
  function automatic logic [63:0] random_operand(bit dp);
    logic [63:0] r;
    int          k;
    r = {$urandom, $urandom};
    k = $urandom_range(9);
    if (k == 4) begin
      r = special_operand(dp);
    end else if (k >= 5 && k <= 7) begin
      if (dp) r[62:52] = 11'(1003 + $urandom_range(40));
      else r[30:23] = 8'(117 + $urandom_range(20));
    end else if (k == 8) begin
      if (dp) r[62:52] = '0;
      else r[30:23] = '0;
    end else if (k == 9) begin
      if (dp) r[62:52] = $urandom_range(1) ? 11'($urandom_range(3)) : 11'(2046 - $urandom_range(3));
      else r[30:23] = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(254 - $urandom_range(3));
    end
    return r;
  endfunction

  task automatic send_random(int n);
    logic [63:0] x, y, z;
    for (int k = 0; k < n; k++) begin
      x = random_operand(fma_sb.dp_mode);
      y = random_operand(fma_sb.dp_mode);
      z = random_operand(fma_sb.dp_mode);
      // Now and then force exact or near cancellation: x*1 - x.
      if ($urandom_range(7) == 0) begin
        y = fma_sb.dp_mode ? 64'h3FF0_0000_0000_0000 : {$urandom, 32'h3F80_0000};
        z = fma_sb.dp_mode ? x ^ SIGN64 : x ^ SIGN32;
        if ($urandom_range(1)) z[0] = ~z[0];
      end
      send_item(x, y, z, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    logic [31:0] d32[12][3] = '{
      '{32'h7F80_0001, 32'h3F80_0000, 32'h7FC0_0000},  // signaling NaN in x
      '{32'h3F80_0000, 32'hFF80_0002, 32'h3F80_0000},  // NaN in y
      '{32'h3F80_0000, 32'h3F80_0000, 32'hFFA0_0000},  // NaN in z
      '{32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000},  // infinity times zero
      '{32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000},  // infinity minus infinity
      '{32'h8000_0000, 32'h3F80_0000, 32'h8000_0000},  // -0 + -0
      '{32'h0000_0000, 32'hBF80_0000, 32'h0000_0000},  // -0 + +0
      '{32'h7F7F_FFFF, 32'h4000_0000, 32'h0000_0000},  // overflow
      '{32'h0000_0001, 32'h3F00_0000, 32'h0000_0000},  // underflow tie to zero
      '{32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000},  // exact cancellation
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},  // all ones
      '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF80_0000}   // huge product plus -inf
    };
    logic [63:0] d64[12][3] = '{
      '{64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'h7FF8_0000_0000_0000},
      '{64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0002, 64'h3FF0_0000_0000_0000},
      '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hFFF4_0000_0000_0000},
      '{64'h7FF0_0000_0000_0000, 64'h0, 64'h3FF0_0000_0000_0000},
      '{64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
      '{64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000},
      '{64'h0, 64'hBFF0_0000_0000_0000, 64'h0},
      '{64'h7FEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'h0},
      '{64'h1, 64'h3FE0_0000_0000_0000, 64'h0},
      '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFF0_0000_0000_0000}
    };
    fma_sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    double_precision = 1'b0;
    in_valid = 1'b0;
    operand_x = '0;
    operand_y = '0;
    addend_z = '0;
    last_in = 1'b0;
    stall_left = 0;
    cycles = 0;
    accepted = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed special cases, binary32 first (the reset mode), then binary64.
    for (int k = 0; k < 12; k++)
      send_item({$urandom, d32[k][0]}, {$urandom, d32[k][1]}, {$urandom, d32[k][2]}, k == 11);
    write_precision(1'b1);
    for (int k = 0; k < 12; k++) send_item(d64[k][0], d64[k][1], d64[k][2], k == 11);

    // Random beats: sender idles more lightly than the receiver.
    snd_idle_pct = 27;
    rcv_idle_pct = 51;
    send_random(240);
    write_precision(1'b0);
    // The other way round.
    snd_idle_pct = 51;
    rcv_idle_pct = 27;
    send_random(240);
    write_precision(1'b1);
    // No idling; a long receiver hold-off fills the pipeline.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random(60);
    stall_left <= 150;
    send_random(60);
    // Sender pauses until everything has come back.
    drain();
    write_precision(1'b0);
    send_random(100);

    drain();
    $display("Checked %0d results from %0d input beats in both precisions,", fma_sb.checked,
             accepted);
    $display("with specials, random operands, back-pressure and a full-pipeline stall.");
    if (fma_sb.errors == 0 && fma_sb.pending_res.size() == 0) begin
      $display("fp_fused_multiply_add test passed");
    end else begin
      $display("fp_fused_multiply_add test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ fp_fused_multiply_add.f @@
+incdir+sv
sv/fpfma_pkg.sv
sv/fpfma_unpack.sv
sv/fpfma_mul.sv
sv/fpfma_align.sv
sv/fpfma_round.sv
sv/fp_fused_multiply_add.sv
tb/testbench.sv
